// File: hw/rtl/yoc_pkg.sv
// ----------------------------------------------------------------------------
// yoc_pkg
// Shared types, constants and helpers for the YUYV to opponent color block.
// ----------------------------------------------------------------------------
package yoc_pkg;

  localparam int KR_V = 91881;
  localparam int KG_V = 46792;
  localparam int KG_U = 21889;
  localparam int KB_U = 116129;
  localparam int RECIP3 = 43691;     // ceil(2^17 / 3)

  localparam int DIV_BITS = 16;      // quotient magnitude bits
  localparam int NUM_W = 25;         // dividend magnitude width
  localparam int FRONT_STAGES = 3;
  localparam int LANE_STAGES = FRONT_STAGES + DIV_BITS;
  localparam int NUM_STAGES = LANE_STAGES + 1;   // plus output register

  localparam logic CFG_DARK_THRESHOLD = 1'b0;
  localparam logic CFG_INPUT_BITS = 1'b1;

  typedef struct packed {
    logic [9:0] dark_threshold;
    logic [4:0] input_bits;
  } yoc_cfg_t;

  typedef struct packed {
    logic signed [16:0] rg;
    logic signed [16:0] by;
    logic [15:0]        lum;
  } yoc_pix_t;

  function automatic logic [7:0] clamp_byte(input logic signed [11:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/yoc_div.sv
// ----------------------------------------------------------------------------
// yoc_div
// Pipelined restoring divider, one quotient bit per stage, signed result.
// ----------------------------------------------------------------------------
module yoc_div (
  input  logic                             clk,
  input  logic [yoc_pkg::DIV_BITS-1:0]     en,
  input  logic [yoc_pkg::NUM_W-1:0]        num,
  input  logic [9:0]                       den,
  input  logic                             neg,
  output logic signed [16:0]               quo
);

  localparam int N = yoc_pkg::DIV_BITS;
  localparam int RW = yoc_pkg::NUM_W + 1;

  logic [yoc_pkg::NUM_W-1:0] rem_r [N];
  logic [N-1:0]              q_r   [N];
  logic [9:0]                d_r   [N];
  logic                      neg_r [N];

  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      if (en[j]) begin
        logic [yoc_pkg::NUM_W-1:0] rin;
        logic [N-1:0]              qin;
        logic [9:0]                din;
        logic [RW-1:0]             sd;
        rin = (j == 0) ? num : rem_r[(j == 0) ? 0 : j - 1];
        qin = (j == 0) ? '0 : q_r[(j == 0) ? 0 : j - 1];
        din = (j == 0) ? den : d_r[(j == 0) ? 0 : j - 1];
        sd = {{(RW-10){1'b0}}, din} << (N - 1 - j);
        if ({1'b0, rin} >= sd) begin
          rem_r[j] <= rin - sd[yoc_pkg::NUM_W-1:0];
          q_r[j]   <= qin | (N'(1) << (N - 1 - j));
        end else begin
          rem_r[j] <= rin;
          q_r[j]   <= qin;
        end
        d_r[j]   <= din;
        neg_r[j] <= (j == 0) ? neg : neg_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  logic signed [16:0] mag;
  assign mag = $signed({1'b0, q_r[N-1]});
  assign quo = neg_r[N-1] ? -mag : mag;

endmodule

// File: hw/rtl/yoc_pixel.sv
// ----------------------------------------------------------------------------
// yoc_pixel
// One pixel lane: YUV to clamped RGB, luminance, opponent numerators, dividers.
// ----------------------------------------------------------------------------
module yoc_pixel (
  input  logic                                 clk,
  input  logic [yoc_pkg::LANE_STAGES-1:0]      en,
  input  yoc_pkg::yoc_cfg_t                    cfg,
  input  logic [7:0]                           y_in,
  input  logic [7:0]                           u_in,
  input  logic [7:0]                           v_in,
  output yoc_pkg::yoc_pix_t                    pix
);

  localparam int F = yoc_pkg::FRONT_STAGES;
  localparam int N = yoc_pkg::DIV_BITS;

  logic signed [8:0]  us, vs;
  logic [7:0]         y1_r, r_r, g_r, b_r;
  logic signed [26:0] pr_r, pgv_r, pgu_r, pb_r;

  assign us = $signed({1'b0, u_in}) - 9'sd128;
  assign vs = $signed({1'b0, v_in}) - 9'sd128;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y1_r  <= y_in;
      pr_r  <= 27'(18'sd91881 * vs);
      pgv_r <= 27'(18'sd46792 * vs);
      pgu_r <= 27'(18'sd21889 * us);
      pb_r  <= 27'(18'sd116129 * us);
    end
  end

  logic signed [11:0] ys, rs, gs, bs;
  assign ys = $signed({4'b0, y1_r});
  assign rs = ys + 12'($signed(pr_r[26:16]));
  assign gs = ys - 12'($signed(pgv_r[26:16])) - 12'($signed(pgu_r[26:16]));
  assign bs = ys + 12'($signed(pb_r[26:16]));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r_r <= yoc_pkg::clamp_byte(rs);
      g_r <= yoc_pkg::clamp_byte(gs);
      b_r <= yoc_pkg::clamp_byte(bs);
    end
  end

  logic [4:0]          bits;
  logic [3:0]          osh, lsh;
  logic [9:0]          l;
  logic [26:0]         lprod;
  logic [15:0]         lum;
  logic signed [11:0]  red, green, blue;
  logic [7:0]          diff;
  logic signed [12:0]  yel;
  logic [9:0]          redc, greenc, bluec, yelc;
  logic signed [11:0]  rgn, byn;
  logic [9:0]          rga, bya;
  logic [11:0]         rg3, by3;
  logic                dark;
  logic [yoc_pkg::NUM_W-1:0] rg_num, by_num;
  logic [9:0]          den;

  always_comb begin
    if (cfg.input_bits < 5'd8) begin
      bits = 5'd8;
    end else if (cfg.input_bits > 5'd16) begin
      bits = 5'd16;
    end else begin
      bits = cfg.input_bits;
    end
    osh = 4'(bits - 5'd3);
    lsh = 4'(bits - 5'd8);
    l = {2'b0, r_r} + {2'b0, g_r} + {2'b0, b_r};
    lprod = 27'(l * 17'd43691);
    lum = {8'b0, lprod[24:17]} << lsh;
    red   = $signed({3'b0, r_r, 1'b0}) - $signed({4'b0, g_r}) - $signed({4'b0, b_r});
    green = $signed({3'b0, g_r, 1'b0}) - $signed({4'b0, r_r}) - $signed({4'b0, b_r});
    blue  = $signed({3'b0, b_r, 1'b0}) - $signed({4'b0, r_r}) - $signed({4'b0, g_r});
    diff = (r_r >= g_r) ? r_r - g_r : g_r - r_r;
    yel = 13'sd0 - $signed({blue, 1'b0}) - $signed({3'b0, diff, 2'b0});
    redc   = red   < 0 ? 10'd0 : red[9:0];
    greenc = green < 0 ? 10'd0 : green[9:0];
    bluec  = blue  < 0 ? 10'd0 : blue[9:0];
    yelc   = yel   < 0 ? 10'd0 : yel[9:0];
    rgn = $signed({2'b0, redc}) - $signed({2'b0, greenc});
    byn = $signed({2'b0, bluec}) - $signed({2'b0, yelc});
    rga = rgn < 0 ? 10'(-rgn) : rgn[9:0];
    bya = byn < 0 ? 10'(-byn) : byn[9:0];
    rg3 = {2'b0, rga} + {1'b0, rga, 1'b0};
    by3 = {2'b0, bya} + {1'b0, bya, 1'b0};
    dark = (l < cfg.dark_threshold) || (l == 10'd0);
    rg_num = dark ? '0 : ({13'b0, rg3} << osh);
    by_num = dark ? '0 : ({13'b0, by3} << osh);
    den = dark ? 10'd1 : l;
  end

  logic [yoc_pkg::NUM_W-1:0] rg_num_r, by_num_r;
  logic [9:0]                den_r;
  logic                      rg_neg_r, by_neg_r;
  logic [15:0]               lum_r [N + 1];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rg_num_r <= rg_num;
      by_num_r <= by_num;
      den_r    <= den;
      rg_neg_r <= rgn < 0;
      by_neg_r <= byn < 0;
      lum_r[0] <= lum;
    end
    for (int j = 0; j < N; j++) begin
      if (en[F + j]) begin
        lum_r[j + 1] <= lum_r[j];
      end
    end
  end

  yoc_div u_div_rg (
    .clk (clk),
    .en  (en[F +: N]),
    .num (rg_num_r),
    .den (den_r),
    .neg (rg_neg_r),
    .quo (pix.rg)
  );

  yoc_div u_div_by (
    .clk (clk),
    .en  (en[F +: N]),
    .num (by_num_r),
    .den (den_r),
    .neg (by_neg_r),
    .quo (pix.by)
  );

  assign pix.lum = lum_r[N];

endmodule

// File: hw/rtl/yoc_merge.sv
// ----------------------------------------------------------------------------
// yoc_merge
// Output register: packs both lanes into one result word.
// ----------------------------------------------------------------------------
module yoc_merge (
  input  logic              clk,
  input  logic              en,
  input  yoc_pkg::yoc_pix_t pix_first,
  input  yoc_pkg::yoc_pix_t pix_second,
  output logic [103:0]      tdata
);

  logic [103:0] data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= {4'b0, pix_second.lum, pix_second.by, pix_second.rg,
                 pix_first.lum, pix_first.by, pix_first.rg};
    end
  end

  assign tdata = data_r;

endmodule

// File: hw/rtl/yuyv_to_opponent_color.sv
// ----------------------------------------------------------------------------
// yuyv_to_opponent_color
// YUYV macropixel to per-pixel luminance and red-green / blue-yellow values.
// ----------------------------------------------------------------------------
// One macropixel word is accepted per clock while back-pressure does not hold
// the pipeline; each result passes through three color stages, the 16-stage divider (one
// quotient bit per stage) and the output register. Every stage stalls only
// when it is full and its successor cannot take, so empty slots absorb a
// stalled output. Configuration writes take effect at once, so make them only
// while the pipeline is idle.
module yuyv_to_opponent_color (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // y_first, u_chroma, y_second, v_chroma
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // rg_first, by_first, lum_first,
                                   // rg_second, by_second, lum_second, pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [9:0]   cfg_data
);

  localparam int NS = yoc_pkg::NUM_STAGES;

  yoc_pkg::yoc_cfg_t cfg_r;
  logic [NS-1:0]     valid_r, valid_nxt, rdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_threshold <= 10'd0;
      cfg_r.input_bits     <= 5'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        yoc_pkg::CFG_DARK_THRESHOLD: cfg_r.dark_threshold <= cfg_data;
        yoc_pkg::CFG_INPUT_BITS:     cfg_r.input_bits     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[NS-1] = !valid_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k + 1];
    end
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        valid_nxt[k] = (k == 0) ? in_tvalid : valid_r[(k == 0) ? 0 : k - 1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = valid_r[NS-1];

  yoc_pkg::yoc_pix_t pix_first, pix_second;

  yoc_pixel u_lane_first (
    .clk  (clk),
    .en   (rdy[NS-2:0]),
    .cfg  (cfg_r),
    .y_in (in_tdata[7:0]),
    .u_in (in_tdata[15:8]),
    .v_in (in_tdata[31:24]),
    .pix  (pix_first)
  );

  yoc_pixel u_lane_second (
    .clk  (clk),
    .en   (rdy[NS-2:0]),
    .cfg  (cfg_r),
    .y_in (in_tdata[23:16]),
    .u_in (in_tdata[15:8]),
    .v_in (in_tdata[31:24]),
    .pix  (pix_second)
  );

  yoc_merge u_merge (
    .clk        (clk),
    .en         (rdy[NS-1]),
    .pix_first  (pix_first),
    .pix_second (pix_second),
    .tdata      (out_tdata)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams YUYV macropixel words through yuyv_to_opponent_color under random
// source gaps and sink stalls. Each result word is checked field by field against
// a fixed-point opponent color model kept in step with the threshold and scaling
// registers, swept across several settings; three directed words use preset results.
// ----------------------------------------------------------------------------
module tb_top;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [9:0]   cfg_data;

  yuyv_to_opponent_color u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct {
    logic [7:0] y0, u, y1, v;
    bit         typed;
    logic [99:0] want;
  } mpix_row_t;

  logic [9:0]  model_thresh;
  logic [4:0]  model_bits;
  logic [99:0] pending_colors[$];
  int          err_count;
  int          idle_cycles;
  int          stall_left;
  bit          stall_free;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int clip8(int x);
    return (x < 0) ? 0 : (x > 255) ? 255 : x;
  endfunction

  // {lum[15:0], by[16:0], rg[16:0]}
  function automatic logic [49:0] opp_pixel(int y, int u, int v);
    longint r, g, b, l, lum, rg, by, red, grn, blu, yel, diff;
    int bits;
    r = clip8(y + int'((longint'(yoc_pkg::KR_V) * v) >>> 16));
    g = clip8(y - int'((longint'(yoc_pkg::KG_V) * v) >>> 16)
              - int'((longint'(yoc_pkg::KG_U) * u) >>> 16));
    b = clip8(y + int'((longint'(yoc_pkg::KB_U) * u) >>> 16));
    bits = model_bits;
    if (bits < 8) bits = 8;
    if (bits > 16) bits = 16;
    l = r + g + b;
    lum = (l / 3) <<< (bits - 8);
    rg = 0;
    by = 0;
    if (l >= model_thresh && l != 0) begin
      red = 2 * r - g - b;
      grn = 2 * g - r - b;
      blu = 2 * b - r - g;
      diff = (r > g) ? r - g : g - r;
      yel = -2 * blu - 4 * diff;
      if (red < 0) red = 0;
      if (grn < 0) grn = 0;
      if (blu < 0) blu = 0;
      if (yel < 0) yel = 0;
      rg = (3 * (red - grn) * (longint'(1) <<< (bits - 3))) / l;
      by = (3 * (blu - yel) * (longint'(1) <<< (bits - 3))) / l;
    end
    return {lum[15:0], by[16:0], rg[16:0]};
  endfunction

  function automatic logic [99:0] opp_macropixel(logic [31:0] w);
    int u, v;
    u = int'(w[15:8]) - 128;
    v = int'(w[31:24]) - 128;
    return {opp_pixel(w[23:16], u, v), opp_pixel(w[7:0], u, v)};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic int gap_len();
    int p;
    if (stall_free) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic [31:0] w, bit typed, logic [99:0] want);
    in_tvalid = 1'b1;
    in_tdata = w;
    do @(posedge clk); while (!in_tready);
    pending_colors.push_back(typed ? want : opp_macropixel(w));
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (gap_len()) @(negedge clk);
  endtask

  task automatic drain();
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == yoc_pkg::CFG_DARK_THRESHOLD) model_thresh = val;
    else model_bits = val[4:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 8'd0;
    if (p == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  // result checking
  always @(posedge clk) begin
    logic [99:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_colors.size() == 0) begin
        report("unexpected word", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_colors.pop_front();
        if (out_tdata[16:0] != want[16:0])
          report("rg_first", out_tdata[16:0], want[16:0]);
        if (out_tdata[33:17] != want[33:17])
          report("by_first", out_tdata[33:17], want[33:17]);
        if (out_tdata[49:34] != want[49:34])
          report("lum_first", out_tdata[49:34], want[49:34]);
        if (out_tdata[66:50] != want[66:50])
          report("rg_second", out_tdata[66:50], want[66:50]);
        if (out_tdata[83:67] != want[83:67])
          report("by_second", out_tdata[83:67], want[83:67]);
        if (out_tdata[99:84] != want[99:84])
          report("lum_second", out_tdata[99:84], want[99:84]);
      end
    end
  end

  // sink stalls: mostly short, now and then a long one
  always @(negedge clk) begin
    int p;
    p = $urandom_range(99);
    if (!rst_n || stall_free) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(199) == 0) begin
      stall_left = $urandom_range(10, 40);
      out_tready <= 1'b0;
    end else if (p < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    mpix_row_t rows[$];
    logic [9:0] thr_set[6];
    logic [4:0] bits_set[6];
    logic [31:0] w;
    int k;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = yoc_pkg::CFG_DARK_THRESHOLD;
    cfg_data = '0;
    err_count = 0;
    idle_cycles = 0;
    stall_free = 1'b0;
    model_thresh = 10'd0;
    model_bits = 5'd8;

    // black, gray and white neutral pixels; then chroma extremes and intermediate values
    rows = '{
      '{8'd0,   8'd128, 8'd0,   8'd128, 1'b1, 100'd0},
      '{8'd255, 8'd128, 8'd255, 8'd128, 1'b1, {16'd255, 34'd0, 16'd255, 34'd0}},
      '{8'd0,   8'd128, 8'd255, 8'd128, 1'b1, {16'd255, 34'd0, 16'd0, 34'd0}},
      '{8'd128, 8'd128, 8'd64,  8'd128, 1'b0, 100'd0},
      '{8'd128, 8'd0,   8'd128, 8'd0,   1'b0, 100'd0},
      '{8'd128, 8'd255, 8'd128, 8'd255, 1'b0, 100'd0},
      '{8'd128, 8'd0,   8'd128, 8'd255, 1'b0, 100'd0},
      '{8'd128, 8'd255, 8'd128, 8'd0,   1'b0, 100'd0},
      '{8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 100'd0},
      '{8'd0,   8'd255, 8'd255, 8'd255, 1'b0, 100'd0},
      '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 100'd0},
      '{8'd255, 8'd255, 8'd0,   8'd0,   1'b0, 100'd0},
      '{8'd1,   8'd127, 8'd2,   8'd129, 1'b0, 100'd0},
      '{8'd16,  8'd90,  8'd235, 8'd200, 1'b0, 100'd0},
      '{8'd80,  8'd170, 8'd40,  8'd60,  1'b0, 100'd0},
      '{8'd200, 8'd60,  8'd30,  8'd180, 1'b0, 100'd0}
    };

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i])
      send_word({rows[i].v, rows[i].y1, rows[i].u, rows[i].y0}, rows[i].typed, rows[i].want);
    drain();

    thr_set  = '{10'd0,  10'd766, 10'd1023, 10'd300, 10'd1,  10'd500};
    bits_set = '{5'd16,  5'd8,    5'd31,    5'd0,    5'd12,  5'd9};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(yoc_pkg::CFG_DARK_THRESHOLD, thr_set[ph]);
      write_reg(yoc_pkg::CFG_INPUT_BITS, {5'd0, bits_set[ph]} );
      stall_free = (ph == 3);
      for (k = 0; k < 165; k++) begin
        w = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
        send_word(w, 1'b0, 100'd0);
        if (ph == 1 && k == 80) while (pending_colors.size() != 0) @(negedge clk);
      end
      stall_free = 1'b0;
      drain();
    end

    if (err_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/yoc_pkg.sv
hw/rtl/yoc_div.sv
hw/rtl/yoc_pixel.sv
hw/rtl/yoc_merge.sv
hw/rtl/yuyv_to_opponent_color.sv
tb/tb_top.sv
